/* rtl/hrp_pkg.sv */
// ----------------------------------------------------------------------------
// hrp_pkg
// Shared types, character codes and helpers for the HTTP response parser.
// ----------------------------------------------------------------------------
package hrp_pkg;

    // parse phase, one-hot
    typedef enum logic [3:0] {
        PH_VERSION = 4'b0001,
        PH_STATUS  = 4'b0010,
        PH_HEADER  = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } phase_t;

    // status class codes
    localparam logic [1:0] CLASS_OK          = 2'd0;
    localparam logic [1:0] CLASS_NOT_FOUND   = 2'd1;
    localparam logic [1:0] CLASS_BAD_REQUEST = 2'd2;

    localparam logic [9:0] CODE_OK        = 10'd200;
    localparam logic [9:0] CODE_NOT_FOUND = 10'd404;
    localparam logic [9:0] CODE_MAX       = 10'd999;

    // character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_UPPER_C = 8'h43;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;

    // header name length, match position width
    localparam int unsigned NAME_LEN = 16;
    localparam logic [4:0]  NAME_POS_LAST = 5'(NAME_LEN - 1);

    // blank line progress codes
    localparam logic [1:0] BL_NONE  = 2'd0;
    localparam logic [1:0] BL_CR1   = 2'd1;
    localparam logic [1:0] BL_LF1   = 2'd2;
    localparam logic [1:0] BL_CR2   = 2'd3;

    // one input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       msg_start;
        logic       msg_end;
    } item_t;

    // one result word
    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic [9:0]  status_code;
        logic [1:0]  status_class;
        logic [31:0] content_length;
        logic        header_done;
    } result_t;

    // lower-case "content-length: " by position
    function automatic logic [7:0] name_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h6f; // o
            4'd2:    c = 8'h6e; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6e; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2d; // -
            4'd8:    c = 8'h6c; // l
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6e; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            4'd14:   c = 8'h3a; // :
            4'd15:   c = 8'h20; // space
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // ascii fold to lower case
    function automatic logic [7:0] to_lower(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
            r = b + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

/* rtl/http_response_header_parser.sv */
// ----------------------------------------------------------------------------
// http_response_header_parser
// Byte-stream HTTP response parser with header fields and payload framing.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one response byte per word, with s_msg_start on the
//   first byte of a buffer (clears all parse state) and s_msg_end on the last.
//   m_ channel returns exactly one word per input word: payload flags and
//   byte, plus the status code, its class, content length and header_done
//   as they stand after that byte.
// Path: each accepted word passes the input register, then the parse
//   update into the output register, which drives m_valid.
// Throughput: one word per cycle while m_ready stays high; the per-byte
//   state update is a single registered step, so back-to-back bytes flow without gaps.
// Reset: synchronous, aresetn low; parse state returns to the version
//   token, all values to zero, both registers empty.
// Stall: while m_ready is low the output word holds; the input register
//   still takes one more word, then s_ready drops until the output drains.
// ----------------------------------------------------------------------------
module http_response_header_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_msg_start,
    input  logic        s_msg_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_payload_valid,
    output logic [7:0]  m_payload_byte,
    output logic        m_payload_last,
    output logic [9:0]  m_status_code,
    output logic [1:0]  m_status_class,
    output logic [31:0] m_content_length,
    output logic        m_header_done
);

    logic             item_valid;
    hrp_pkg::item_t   item;
    hrp_pkg::result_t result;
    hrp_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             advance;

    // parse a word when the output register is free or draining
    assign advance = item_valid && (!out_valid_reg || m_ready);

    hrp_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_msg_start (s_msg_start),
        .s_msg_end   (s_msg_end),
        .advance     (advance),
        .item_valid  (item_valid),
        .item        (item)
    );

    hrp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= item_valid;
        end
    end

    // output word
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_payload_valid  = out_reg.payload_valid;
    assign m_payload_byte   = out_reg.payload_byte;
    assign m_payload_last   = out_reg.payload_last;
    assign m_status_code    = out_reg.status_code;
    assign m_status_class   = out_reg.status_class;
    assign m_content_length = out_reg.content_length;
    assign m_header_done    = out_reg.header_done;

endmodule

/* rtl/hrp_in_stage.sv */
// ----------------------------------------------------------------------------
// hrp_in_stage
// Input register: holds one byte word until the parse stage takes it.
// ----------------------------------------------------------------------------
module hrp_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_data_byte,
    input  logic           s_msg_start,
    input  logic           s_msg_end,
    input  logic           advance,
    output logic           item_valid,
    output hrp_pkg::item_t item
);

    logic           valid_reg;
    hrp_pkg::item_t item_reg;

    // free when empty or when the held word moves on this cycle
    assign s_ready = !valid_reg || advance;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.data_byte <= s_data_byte;
            item_reg.msg_start <= s_msg_start;
            item_reg.msg_end   <= s_msg_end;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/hrp_core.sv */
// ----------------------------------------------------------------------------
// hrp_core
// Parse state and its per-byte update: version skip, status code, header
// name match with length digits, blank line search and payload counting.
// ----------------------------------------------------------------------------
module hrp_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  hrp_pkg::item_t   item,
    output hrp_pkg::result_t result
);

    hrp_pkg::phase_t phase_reg, phase_next;
    logic [9:0]  code_reg, code_next;
    logic [31:0] len_reg, len_next;
    logic [4:0]  name_pos_reg, name_pos_next;
    logic        digits_reg, digits_next;
    logic [1:0]  blank_reg, blank_next;
    logic [31:0] count_reg, count_next;
    logic        seen_reg, seen_next;

    logic [7:0]  b;
    logic        b_digit;
    logic [3:0]  b_val;
    logic [13:0] code_mul;
    logic [35:0] len_mul;
    logic [7:0]  name_ch;
    logic        pay_valid;
    logic        pay_last;
    logic [1:0]  cls;

    assign b       = item.data_byte;
    assign b_digit = hrp_pkg::is_digit(b);
    assign b_val   = b[3:0];

    // next state, in the order the byte is interpreted
    always_comb begin
        phase_next    = phase_reg;
        code_next     = code_reg;
        len_next      = len_reg;
        name_pos_next = name_pos_reg;
        digits_next   = digits_reg;
        blank_next    = blank_reg;
        count_next    = count_reg;
        seen_next     = seen_reg;
        pay_valid     = 1'b0;
        pay_last      = 1'b0;
        code_mul      = '0;
        len_mul       = '0;
        name_ch       = '0;

        // start of a buffer clears everything
        if (item.msg_start) begin
            phase_next    = hrp_pkg::PH_VERSION;
            code_next     = '0;
            len_next      = '0;
            name_pos_next = '0;
            digits_next   = 1'b0;
            blank_next    = hrp_pkg::BL_NONE;
            count_next    = '0;
            seen_next     = 1'b0;
        end

        if (phase_next == hrp_pkg::PH_PAYLOAD) begin
            // payload pass-through
            if (len_next == '0 || count_next < len_next) begin
                pay_valid = 1'b1;
                if (item.msg_end || (len_next != '0 && count_next + 32'd1 == len_next)) begin
                    pay_last = 1'b1;
                end
                if (count_next != '1) begin
                    count_next = count_next + 32'd1;
                end
            end
        end else begin
            // first line: version then status token
            case (phase_next)
                hrp_pkg::PH_VERSION: begin
                    if (b == hrp_pkg::CH_SPACE) begin
                        phase_next  = hrp_pkg::PH_STATUS;
                        digits_next = 1'b1;
                    end else if (b == hrp_pkg::CH_CR) begin
                        phase_next = hrp_pkg::PH_HEADER;
                    end
                end
                hrp_pkg::PH_STATUS: begin
                    if (b == hrp_pkg::CH_SPACE || b == hrp_pkg::CH_CR) begin
                        phase_next  = hrp_pkg::PH_HEADER;
                        digits_next = 1'b0;
                    end else if (digits_next && b_digit) begin
                        code_mul = {1'b0, code_next, 3'b000} + {3'b000, code_next, 1'b0}
                                 + {10'd0, b_val};
                        code_next = (code_mul > {4'd0, hrp_pkg::CODE_MAX})
                                  ? hrp_pkg::CODE_MAX : code_mul[9:0];
                    end else begin
                        digits_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase

            // length value digits
            if (phase_next != hrp_pkg::PH_STATUS && digits_next) begin
                if (b_digit) begin
                    len_mul = {1'b0, len_next, 3'b000} + {3'b000, len_next, 1'b0}
                            + {32'd0, b_val};
                    len_next = (len_mul[35:32] != 4'd0) ? '1 : len_mul[31:0];
                end else begin
                    digits_next = 1'b0;
                end
            end

            // header name match, first letter upper case only
            name_ch = hrp_pkg::name_char(name_pos_next[3:0]);
            if (name_pos_next == '0) begin
                name_pos_next = (b == hrp_pkg::CH_UPPER_C) ? 5'd1 : 5'd0;
            end else if (hrp_pkg::to_lower(b) == name_ch) begin
                if (name_pos_next == hrp_pkg::NAME_POS_LAST) begin
                    name_pos_next = '0;
                    len_next      = '0;
                    if (phase_next != hrp_pkg::PH_STATUS) begin
                        digits_next = 1'b1;
                    end
                end else begin
                    name_pos_next = name_pos_next + 5'd1;
                end
            end else begin
                name_pos_next = (b == hrp_pkg::CH_UPPER_C) ? 5'd1 : 5'd0;
            end

            // blank line search
            case (blank_next)
                hrp_pkg::BL_CR1: begin
                    blank_next = (b == hrp_pkg::CH_LF) ? hrp_pkg::BL_LF1 :
                                 (b == hrp_pkg::CH_CR) ? hrp_pkg::BL_CR1 : hrp_pkg::BL_NONE;
                end
                hrp_pkg::BL_LF1: begin
                    blank_next = (b == hrp_pkg::CH_CR) ? hrp_pkg::BL_CR2 : hrp_pkg::BL_NONE;
                end
                hrp_pkg::BL_CR2: begin
                    if (b == hrp_pkg::CH_LF) begin
                        blank_next    = hrp_pkg::BL_NONE;
                        seen_next     = 1'b1;
                        phase_next    = hrp_pkg::PH_PAYLOAD;
                        count_next    = '0;
                        digits_next   = 1'b0;
                        name_pos_next = '0;
                    end else begin
                        blank_next = (b == hrp_pkg::CH_CR) ? hrp_pkg::BL_CR1 : hrp_pkg::BL_NONE;
                    end
                end
                default: begin
                    blank_next = (b == hrp_pkg::CH_CR) ? hrp_pkg::BL_CR1 : hrp_pkg::BL_NONE;
                end
            endcase
        end
    end

    // status class
    always_comb begin
        if (code_next == hrp_pkg::CODE_OK) begin
            cls = hrp_pkg::CLASS_OK;
        end else if (code_next == hrp_pkg::CODE_NOT_FOUND) begin
            cls = hrp_pkg::CLASS_NOT_FOUND;
        end else begin
            cls = hrp_pkg::CLASS_BAD_REQUEST;
        end
    end

    // result word for the output register
    always_comb begin
        result.payload_valid  = pay_valid;
        result.payload_byte   = pay_valid ? b : 8'd0;
        result.payload_last   = pay_last;
        result.status_code    = code_next;
        result.status_class   = cls;
        result.content_length = len_next;
        result.header_done    = seen_next;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= hrp_pkg::PH_VERSION;
            code_reg     <= '0;
            len_reg      <= '0;
            name_pos_reg <= '0;
            digits_reg   <= 1'b0;
            blank_reg    <= hrp_pkg::BL_NONE;
            count_reg    <= '0;
            seen_reg     <= 1'b0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            code_reg     <= code_next;
            len_reg      <= len_next;
            name_pos_reg <= name_pos_next;
            digits_reg   <= digits_next;
            blank_reg    <= blank_next;
            count_reg    <= count_next;
            seen_reg     <= seen_next;
        end
    end

endmodule

/* tb/http_response_header_parser_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http_response_header_parser_tb
// Streams HTTP responses, broken responses and random noise into the parser
// one word per byte, with random gaps on the sender and random stalls on the
// receiver. A byte-level predictor tracks the parse state and builds the
// expected result word for every byte. Each result is checked field by field
// against the oldest expected word.
// ----------------------------------------------------------------------------
module http_response_header_parser_tb;

    localparam int unsigned CLK_PERIOD  = 10;
    localparam int unsigned ITEM_TARGET = 900;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PRINT_LIMIT = 40;
    localparam string       CRLF        = "\015\012";
    // header name as matched after folding to lower case
    localparam logic [8*16-1:0] FIELD_NAME = "content-length: ";

    typedef struct packed {
        hrp_pkg::item_t word;
        logic           drain;   // hold off until every result is back
    } tx_entry_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_msg_start = 1'b0;
    logic        s_msg_end   = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic        m_payload_valid;
    logic [7:0]  m_payload_byte;
    logic        m_payload_last;
    logic [9:0]  m_status_code;
    logic [1:0]  m_status_class;
    logic [31:0] m_content_length;
    logic        m_header_done;

    http_response_header_parser u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_msg_start     (s_msg_start),
        .s_msg_end       (s_msg_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload_valid (m_payload_valid),
        .m_payload_byte  (m_payload_byte),
        .m_payload_last  (m_payload_last),
        .m_status_code   (m_status_code),
        .m_status_class  (m_status_class),
        .m_content_length(m_content_length),
        .m_header_done   (m_header_done)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // stimulus and expected words
    logic [7:0]        msg_buf[$];
    tx_entry_t         tx_words[$];
    hrp_pkg::result_t  pending_results[$];

    // predicted parse state
    hrp_pkg::phase_t cur_phase    = hrp_pkg::PH_VERSION;
    logic [9:0]      code_acc     = '0;
    logic [31:0]     length_acc   = '0;
    int unsigned     name_hits    = 0;
    logic            digit_mode   = 1'b0;
    logic [1:0]      blank_track  = hrp_pkg::BL_NONE;
    logic [31:0]     body_count   = '0;
    logic            hdr_complete = 1'b0;

    // run bookkeeping
    int unsigned error_count  = 0;
    int unsigned result_count = 0;
    int unsigned msg_count    = 0;
    int unsigned noise_bursts = 0;
    int unsigned body_bytes   = 0;
    int unsigned headers_done = 0;
    int unsigned cycle_count  = 0;
    int unsigned send_gap     = 0;
    int unsigned ready_hold   = 0;
    bit          idle_on      = 1'b1;

    // gap length for one word; idling switches on and off in stretches
    function automatic int unsigned idle_draw();
        if ($urandom_range(0, 49) == 0) begin
            idle_on = !idle_on;
        end
        return idle_on ? $urandom_range(0, 18) : 0;
    endfunction

    task automatic flag_error(input string msg);
        if (error_count < PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            flag_error($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                 result_count, name, got, want));
        end
    endtask

    // advance the parse by one byte and queue the word it should produce
    task automatic parse_byte(input logic [7:0] b, input logic first, input logic fin);
        hrp_pkg::result_t r;
        logic             is_num;
        logic [7:0]       folded;
        int unsigned      code_next;
        logic [63:0]      wide;
        if (first) begin
            cur_phase    = hrp_pkg::PH_VERSION;
            code_acc     = '0;
            length_acc   = '0;
            name_hits    = 0;
            digit_mode   = 1'b0;
            blank_track  = hrp_pkg::BL_NONE;
            body_count   = '0;
            hdr_complete = 1'b0;
        end
        r      = '0;
        is_num = (b >= hrp_pkg::CH_ZERO) && (b <= hrp_pkg::CH_NINE);
        folded = (b >= hrp_pkg::CH_UPPER_A && b <= hrp_pkg::CH_UPPER_Z) ? b + 8'd32 : b;

        if (cur_phase == hrp_pkg::PH_PAYLOAD) begin
            // payload runs to the length, or forever when the length is zero
            if (length_acc == 0 || body_count < length_acc) begin
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                r.payload_last  = fin || (length_acc != 0 &&
                                  {1'b0, body_count} + 33'd1 == {1'b0, length_acc});
                if (body_count != '1) begin
                    body_count++;
                end
                body_bytes++;
            end
        end else begin
            // first line: version token, then status code token
            case (cur_phase)
                hrp_pkg::PH_VERSION: begin
                    if (b == hrp_pkg::CH_SPACE) begin
                        cur_phase  = hrp_pkg::PH_STATUS;
                        digit_mode = 1'b1;
                    end else if (b == hrp_pkg::CH_CR) begin
                        cur_phase = hrp_pkg::PH_HEADER;
                    end
                end
                hrp_pkg::PH_STATUS: begin
                    if (b == hrp_pkg::CH_SPACE || b == hrp_pkg::CH_CR) begin
                        cur_phase  = hrp_pkg::PH_HEADER;
                        digit_mode = 1'b0;
                    end else if (digit_mode && is_num) begin
                        code_next = int'(code_acc) * 10 + int'(b) - int'(hrp_pkg::CH_ZERO);
                        code_acc  = (code_next > hrp_pkg::CODE_MAX) ? hrp_pkg::CODE_MAX
                                                                   : code_next[9:0];
                    end else begin
                        digit_mode = 1'b0;
                    end
                end
                default: ;
            endcase

            // content-length value digits
            if (cur_phase != hrp_pkg::PH_STATUS && digit_mode) begin
                if (is_num) begin
                    wide       = 64'(length_acc) * 64'd10 + 64'(b - hrp_pkg::CH_ZERO);
                    length_acc = (wide > 64'hFFFF_FFFF) ? '1 : wide[31:0];
                end else begin
                    digit_mode = 1'b0;
                end
            end

            // header name match, upper-case C then case-folded remainder
            if (name_hits == 0 || name_hits >= hrp_pkg::NAME_LEN) begin
                name_hits = (b == hrp_pkg::CH_UPPER_C) ? 1 : 0;
            end else if (folded == FIELD_NAME[8*(hrp_pkg::NAME_LEN-1-name_hits) +: 8]) begin
                name_hits++;
                if (name_hits == hrp_pkg::NAME_LEN) begin
                    name_hits  = 0;
                    length_acc = '0;
                    if (cur_phase != hrp_pkg::PH_STATUS) begin
                        digit_mode = 1'b1;
                    end
                end
            end else begin
                name_hits = (b == hrp_pkg::CH_UPPER_C) ? 1 : 0;
            end

            // blank line search
            case (blank_track)
                hrp_pkg::BL_CR1: begin
                    blank_track = (b == hrp_pkg::CH_LF) ? hrp_pkg::BL_LF1 :
                                  (b == hrp_pkg::CH_CR) ? hrp_pkg::BL_CR1 : hrp_pkg::BL_NONE;
                end
                hrp_pkg::BL_LF1: begin
                    blank_track = (b == hrp_pkg::CH_CR) ? hrp_pkg::BL_CR2 : hrp_pkg::BL_NONE;
                end
                hrp_pkg::BL_CR2: begin
                    if (b == hrp_pkg::CH_LF) begin
                        blank_track  = hrp_pkg::BL_NONE;
                        hdr_complete = 1'b1;
                        cur_phase    = hrp_pkg::PH_PAYLOAD;
                        body_count   = '0;
                        digit_mode   = 1'b0;
                        name_hits    = 0;
                        headers_done++;
                    end else begin
                        blank_track = (b == hrp_pkg::CH_CR) ? hrp_pkg::BL_CR1
                                                            : hrp_pkg::BL_NONE;
                    end
                end
                default: begin
                    blank_track = (b == hrp_pkg::CH_CR) ? hrp_pkg::BL_CR1 : hrp_pkg::BL_NONE;
                end
            endcase
        end

        r.status_code    = code_acc;
        r.status_class   = (code_acc == hrp_pkg::CODE_OK)        ? hrp_pkg::CLASS_OK :
                           (code_acc == hrp_pkg::CODE_NOT_FOUND) ? hrp_pkg::CLASS_NOT_FOUND
                                                                 : hrp_pkg::CLASS_BAD_REQUEST;
        r.content_length = length_acc;
        r.header_done    = hdr_complete;
        pending_results.push_back(r);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            msg_buf.push_back(s[i]);
        end
    endtask

    // header name with random letter case; a bad one breaks the match
    task automatic add_name(input bit good);
        int unsigned bad_at;
        logic [7:0]  ch;
        bad_at = good ? hrp_pkg::NAME_LEN : $urandom_range(0, hrp_pkg::NAME_LEN - 1);
        for (int i = 0; i < hrp_pkg::NAME_LEN; i++) begin
            ch = FIELD_NAME[8*(hrp_pkg::NAME_LEN-1-i) +: 8];
            if (i == 0) begin
                ch = hrp_pkg::CH_UPPER_C;
            end else if (ch >= "a" && ch <= "z" && $urandom_range(0, 1)) begin
                ch = ch - 8'd32;
            end
            if (i == bad_at) begin
                ch = (i == 0) ? "c" : "_";
            end
            msg_buf.push_back(ch);
        end
    endtask

    // move the buffered bytes out as one response
    task automatic ship(input bit drain, input int end_at);
        tx_entry_t e;
        for (int i = 0; i < msg_buf.size(); i++) begin
            e.word.data_byte = msg_buf[i];
            e.word.msg_start = (i == 0);
            e.word.msg_end   = (i == end_at);
            e.drain          = drain && (i == 0);
            tx_words.push_back(e);
        end
        msg_buf.delete();
        msg_count++;
    endtask

    // random words with random start and end flags
    task automatic add_noise();
        tx_entry_t e;
        repeat ($urandom_range(1, 16)) begin
            e.word.data_byte = 8'($urandom);
            e.word.msg_start = ($urandom_range(0, 7) == 0);
            e.word.msg_end   = ($urandom_range(0, 7) == 0);
            e.drain          = 1'b0;
            tx_words.push_back(e);
        end
        noise_bursts++;
    endtask

    // response with random content, at times malformed, sometimes cut short
    task automatic build_response(input bit drain);
        int unsigned len_val;
        int unsigned pick;
        int unsigned body_len;
        int unsigned cut;
        int          end_at;
        len_val = 0;
        case ($urandom_range(0, 3))
            0: add_text("HTTP/1.1");
            1: add_text("HTTP/1.0");
            2: add_text("H");
            default: ;
        endcase
        // now and then the version runs straight into the line end
        if ($urandom_range(0, 9) != 0) begin
            add_text(" ");
            case ($urandom_range(0, 7))
                0, 1: add_text("200");
                2: add_text("404");
                3: add_text($sformatf("%0d", $urandom_range(0, 999)));
                4: add_text($sformatf("%0d", $urandom_range(1000, 999999)));
                5: add_text($sformatf("%s%0d", $urandom_range(0, 1) ? "-" : "+",
                                      $urandom_range(0, 500)));
                6: add_text($sformatf("%0dx%0d", $urandom_range(0, 99), $urandom_range(0, 9)));
                default: ;
            endcase
            if ($urandom_range(0, 1)) begin
                add_text(" OK");
            end
        end
        add_text(CRLF);

        // header lines, a repeated content-length keeps the last value
        repeat ($urandom_range(0, 3)) begin
            pick = $urandom_range(0, 7);
            if (pick <= 3) begin
                len_val = $urandom_range(0, 12);
                add_name(1'b1);
                add_text($sformatf("%0d", len_val));
            end else if (pick == 4) begin
                len_val = 32'hFFFF_FFFF;
                add_name(1'b1);
                if ($urandom_range(0, 1)) begin
                    add_text("4294967295");
                end else begin
                    add_text($sformatf("%0d%0d", $urandom_range(429497, 999999),
                                       $urandom_range(10000, 99999)));
                end
            end else if (pick == 5) begin
                add_name(1'b0);
                add_text("7");
            end else begin
                add_text("Host: a");
            end
            add_text(CRLF);
        end
        add_text(CRLF);

        // payload, at times running past the length
        if (len_val == 0) begin
            body_len = $urandom_range(0, 12);
        end else begin
            body_len = $urandom_range(0, (len_val > 20) ? 24 : len_val + 4);
        end
        repeat (body_len) begin
            msg_buf.push_back(8'($urandom));
        end

        if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, msg_buf.size());
            while (msg_buf.size() > cut) begin
                void'(msg_buf.pop_back());
            end
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            end_at = -1;
        end else if (pick == 1) begin
            end_at = $urandom_range(0, msg_buf.size() - 1);
        end else begin
            end_at = msg_buf.size() - 1;
        end
        ship(drain, end_at);
    endtask

    // driver: one word at a time from tx_words
    always @(posedge aclk) begin
        tx_entry_t e;
        logic      offer;
        if (aresetn) begin
            offer = s_valid && !s_ready;
            if (!offer) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                end else if (tx_words.size() != 0 &&
                             !(tx_words[0].drain && (pending_results.size() != 0 || s_valid))) begin
                    e = tx_words.pop_front();
                    s_data_byte <= e.word.data_byte;
                    s_msg_start <= e.word.msg_start;
                    s_msg_end   <= e.word.msg_end;
                    send_gap    <= idle_draw();
                    offer = 1'b1;
                end
            end
            s_valid <= offer;
        end
    end

    // monitor: check results, stall the output, predict accepted bytes
    always @(posedge aclk) begin
        hrp_pkg::result_t want;
        int unsigned      stall;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    flag_error($sformatf("result %0d arrived with nothing expected",
                                         result_count));
                end else begin
                    want = pending_results.pop_front();
                    check_field("payload_valid", 32'(m_payload_valid),
                                32'(want.payload_valid));
                    check_field("payload_byte", 32'(m_payload_byte), 32'(want.payload_byte));
                    check_field("payload_last", 32'(m_payload_last), 32'(want.payload_last));
                    check_field("status_code", 32'(m_status_code), 32'(want.status_code));
                    check_field("status_class", 32'(m_status_class), 32'(want.status_class));
                    check_field("content_length", m_content_length, want.content_length);
                    check_field("header_done", 32'(m_header_done), 32'(want.header_done));
                end
                result_count++;
                stall = idle_draw();
                if (stall != 0) begin
                    m_ready    <= 1'b0;
                    ready_hold <= stall;
                end
            end else if (!m_ready) begin
                if (ready_hold <= 1) begin
                    m_ready <= 1'b1;
                end else begin
                    ready_hold <= ready_hold - 1;
                end
            end
            if (s_valid && s_ready) begin
                parse_byte(s_data_byte, s_msg_start, s_msg_end);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int unsigned directed_words;
        // directed: not found code with zero and all-ones payload bytes
        add_text("H 404");
        add_text(CRLF);
        add_text(CRLF);
        msg_buf.push_back(8'h00);
        msg_buf.push_back(8'hFF);
        ship(1'b0, msg_buf.size() - 1);
        // directed: version ends at the line end, code stays zero
        add_text(CRLF);
        add_text(CRLF);
        msg_buf.push_back(8'h7F);
        ship(1'b0, msg_buf.size() - 1);
        // directed: empty version token, code saturates
        add_text(" 2000");
        add_text(CRLF);
        add_text(CRLF);
        add_text("Z");
        ship(1'b0, msg_buf.size() - 1);
        directed_words = tx_words.size();

        // random part, first response waits for the pipe to drain
        while (tx_words.size() < directed_words + ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
                add_noise();
            end else begin
                build_response(msg_count == 3 || $urandom_range(0, 9) == 0);
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (tx_words.size() != 0 || s_valid) @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("sent %0d words: %0d responses and %0d noise bursts, %0d results checked",
                 result_count, msg_count, noise_bursts, result_count);
        $display("headers completed %0d times, %0d payload bytes predicted, %0d errors",
                 headers_done, body_bytes, error_count);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
